[rtl/core/hrf_pkg.sv]
`timescale 1ns / 1ps

package hrf_pkg;

    localparam int FIELD_W     = 32;
    localparam int NAME_LEN    = 14;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } hrf_in_t;

    typedef struct packed {
        logic                complete;
        logic [FIELD_W-1:0]  request_length;
        logic [FIELD_W-1:0]  content_length;
    } hrf_out_t;

    // Byte with its class flags, as queued between front and back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       is_cr;
        logic       is_lf;
        logic       is_colon;
        logic       is_ws;
        logic       is_sign;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
    } hrf_cls_t;

    typedef enum logic [1:0] {
        PH_REQUEST,
        PH_HEADERS,
        PH_BODY
    } hrf_phase_t;

    typedef enum logic [1:0] {
        VS_SKIP,
        VS_SIGN,
        VS_DIGITS,
        VS_DONE
    } hrf_vstage_t;

    // Characters of the Content-Length header name.
    function automatic logic [7:0] cl_name_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/http_request_framer_unit.sv]
`timescale 1ns / 1ps

// HTTP request framer: takes one byte per clock of a buffered request and,
// for the byte marked end_of_buffer, returns one result with the completion
// flag, request length and Content-Length value. Sustained rate is one byte
// per clock while the result port takes results, as the back stage parses
// each byte combinationally (the multiply-by-ten accumulate of the length
// value). The result of the marked byte passes the front register, a queue
// entry, the snapshot register behind the back parse, then the output
// register that holds the computed result, where m_valid rises. A held-off
// result port holds the result there and backs up the path behind it. A short
// queue between the classifying front and the parsing back absorbs stalls on
// either side; no input is lost while the result port is held off, and
// counters saturate at 2^COUNT_WIDTH - 1.
module http_request_framer_unit
    import hrf_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hrf_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output hrf_out_t m_item
);

    logic                   f_push;
    logic                   f_ready;
    hrf_cls_t               f_data;
    logic                   q_valid;
    logic                   q_ready;
    hrf_cls_t               q_data;
    logic                   snap_valid;
    logic                   snap_ready;
    logic                   snap_body_phase;
    logic [COUNT_WIDTH-1:0] snap_bytes;
    logic [COUNT_WIDTH-1:0] snap_committed;
    logic [COUNT_WIDTH-1:0] snap_body;

    hrf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_push  (f_push),
        .q_ready (f_ready),
        .q_data  (f_data)
    );

    hrf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_push),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    hrf_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_data          (q_data),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap_body_phase (snap_body_phase),
        .snap_bytes      (snap_bytes),
        .snap_committed  (snap_committed),
        .snap_body       (snap_body)
    );

    hrf_emit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap_body_phase (snap_body_phase),
        .snap_bytes      (snap_bytes),
        .snap_committed  (snap_committed),
        .snap_body       (snap_body),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item)
    );

endmodule

[rtl/core/hrf_front.sv]
`timescale 1ns / 1ps

module hrf_front
    import hrf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hrf_in_t  s_item,
    output logic     q_push,
    input  logic     q_ready,
    output hrf_cls_t q_data
);

    logic     valid_reg;
    hrf_cls_t cls_reg;
    hrf_cls_t cls_next;
    logic     advance;

    always_comb begin
        cls_next.data_byte = s_item.data_byte;
        cls_next.last      = s_item.end_of_buffer;
        cls_next.is_cr     = (s_item.data_byte == CH_CR);
        cls_next.is_lf     = (s_item.data_byte == CH_LF);
        cls_next.is_colon  = (s_item.data_byte == CH_COLON);
        cls_next.is_ws     = (s_item.data_byte == CH_SPACE) ||
                             ((s_item.data_byte >= CH_TAB) && (s_item.data_byte <= CH_CR));
        cls_next.is_sign   = (s_item.data_byte == CH_PLUS) || (s_item.data_byte == CH_MINUS);
        cls_next.is_minus  = (s_item.data_byte == CH_MINUS);
        cls_next.is_digit  = (s_item.data_byte >= CH_ZERO) && (s_item.data_byte <= CH_NINE);
        cls_next.digit     = 4'(s_item.data_byte - CH_ZERO);
    end

    assign advance = !valid_reg || q_ready;
    assign s_ready = advance;
    assign q_push  = valid_reg;
    assign q_data  = cls_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            cls_reg <= cls_next;
        end
    end

endmodule

[rtl/core/hrf_queue.sv]
`timescale 1ns / 1ps

module hrf_queue
    import hrf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  hrf_cls_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output hrf_cls_t rd_data
);

    hrf_cls_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/hrf_back.sv]
`timescale 1ns / 1ps

module hrf_back
    import hrf_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  hrf_cls_t               q_data,
    output logic                   snap_valid,
    input  logic                   snap_ready,
    output logic                   snap_body_phase,
    output logic [COUNT_WIDTH-1:0] snap_bytes,
    output logic [COUNT_WIDTH-1:0] snap_committed,
    output logic [COUNT_WIDTH-1:0] snap_body
);

    localparam logic [COUNT_WIDTH-1:0] MAXV = '1;

    hrf_phase_t             phase_reg,     phase_next;
    logic                   prev_cr_reg,   prev_cr_next;
    logic [COUNT_WIDTH-1:0] bytes_reg,     bytes_next;
    logic [COUNT_WIDTH-1:0] commit_reg,    commit_next;
    logic                   colon_reg,     colon_next;
    logic [3:0]             mpos_reg,      mpos_next;
    logic                   match_reg,     match_next;
    hrf_vstage_t            vstage_reg,    vstage_next;
    logic                   neg_reg,       neg_next;
    logic [COUNT_WIDTH-1:0] pend_reg,      pend_next;
    logic [COUNT_WIDTH-1:0] body_reg,      body_next;

    logic                   pop;
    logic                   line_end;
    logic                   name_hit;
    logic [COUNT_WIDTH+3:0] acc;
    logic [COUNT_WIDTH-1:0] pend_acc;

    assign q_ready    = !q_data.last || snap_ready;
    assign pop        = q_valid && q_ready;
    assign snap_valid = q_valid && q_data.last;

    assign line_end = q_data.is_lf && prev_cr_reg;
    assign name_hit = match_reg && (mpos_reg < 4'(NAME_LEN)) &&
                      (q_data.data_byte == cl_name_char(mpos_reg));

    // pending * 10 + digit, clamp at the counter maximum
    assign acc = ({4'b0, pend_reg} << 3) + ({4'b0, pend_reg} << 1) +
                 (COUNT_WIDTH+4)'(q_data.digit);
    assign pend_acc = (acc[COUNT_WIDTH+3:COUNT_WIDTH] != 4'b0) ? MAXV : acc[COUNT_WIDTH-1:0];

    always_comb begin
        phase_next   = phase_reg;
        prev_cr_next = prev_cr_reg;
        bytes_next   = (bytes_reg == MAXV) ? bytes_reg : bytes_reg + 1'b1;
        commit_next  = commit_reg;
        colon_next   = colon_reg;
        mpos_next    = mpos_reg;
        match_next   = match_reg;
        vstage_next  = vstage_reg;
        neg_next     = neg_reg;
        pend_next    = pend_reg;
        body_next    = body_reg;

        if (phase_reg == PH_REQUEST || phase_reg == PH_HEADERS) begin
            if (line_end) begin
                commit_next = bytes_next;
                if (phase_reg == PH_REQUEST) begin
                    phase_next = PH_HEADERS;
                end else if (colon_reg) begin
                    if (match_reg && mpos_reg == 4'(NAME_LEN)) begin
                        body_next = (neg_reg && pend_reg != '0) ? MAXV : pend_reg;
                    end
                end else begin
                    phase_next = PH_BODY;
                end
                colon_next   = 1'b0;
                mpos_next    = '0;
                match_next   = 1'b1;
                vstage_next  = VS_SKIP;
                neg_next     = 1'b0;
                pend_next    = '0;
                prev_cr_next = 1'b0;
            end else begin
                if (phase_reg == PH_HEADERS) begin
                    if (colon_reg) begin
                        case (vstage_reg)
                            VS_SKIP: begin
                                if (q_data.is_sign) begin
                                    neg_next    = q_data.is_minus;
                                    vstage_next = VS_SIGN;
                                end else if (!q_data.is_ws) begin
                                    vstage_next = q_data.is_digit ? VS_DIGITS : VS_DONE;
                                end
                            end
                            VS_SIGN:   vstage_next = q_data.is_digit ? VS_DIGITS : VS_DONE;
                            VS_DIGITS: vstage_next = q_data.is_digit ? VS_DIGITS : VS_DONE;
                            default:   vstage_next = VS_DONE;
                        endcase
                        if (q_data.is_digit && vstage_reg != VS_DONE) begin
                            pend_next = pend_acc;
                        end
                    end else if (q_data.is_colon) begin
                        colon_next = 1'b1;
                    end else if (name_hit) begin
                        mpos_next = mpos_reg + 1'b1;
                    end else begin
                        match_next = 1'b0;
                    end
                end
                prev_cr_next = q_data.is_cr;
            end
        end
    end

    assign snap_body_phase = (phase_next == PH_BODY);
    assign snap_bytes      = bytes_next;
    assign snap_committed  = commit_next;
    assign snap_body       = body_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_REQUEST;
            prev_cr_reg <= 1'b0;
            bytes_reg   <= '0;
            commit_reg  <= '0;
            colon_reg   <= 1'b0;
            mpos_reg    <= '0;
            match_reg   <= 1'b1;
            vstage_reg  <= VS_SKIP;
            neg_reg     <= 1'b0;
            pend_reg    <= '0;
            body_reg    <= '0;
        end else if (pop) begin
            if (q_data.last) begin
                // result taken, start over for the next buffer
                phase_reg   <= PH_REQUEST;
                prev_cr_reg <= 1'b0;
                bytes_reg   <= '0;
                commit_reg  <= '0;
                colon_reg   <= 1'b0;
                mpos_reg    <= '0;
                match_reg   <= 1'b1;
                vstage_reg  <= VS_SKIP;
                neg_reg     <= 1'b0;
                pend_reg    <= '0;
                body_reg    <= '0;
            end else begin
                phase_reg   <= phase_next;
                prev_cr_reg <= prev_cr_next;
                bytes_reg   <= bytes_next;
                commit_reg  <= commit_next;
                colon_reg   <= colon_next;
                mpos_reg    <= mpos_next;
                match_reg   <= match_next;
                vstage_reg  <= vstage_next;
                neg_reg     <= neg_next;
                pend_reg    <= pend_next;
                body_reg    <= body_next;
            end
        end
    end

endmodule

[rtl/core/hrf_emit.sv]
`timescale 1ns / 1ps

module hrf_emit
    import hrf_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   snap_valid,
    output logic                   snap_ready,
    input  logic                   snap_body_phase,
    input  logic [COUNT_WIDTH-1:0] snap_bytes,
    input  logic [COUNT_WIDTH-1:0] snap_committed,
    input  logic [COUNT_WIDTH-1:0] snap_body,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hrf_out_t               m_item
);

    localparam logic [COUNT_WIDTH-1:0] MAXV = '1;

    logic                   s1_valid_reg;
    logic                   s1_body_phase_reg;
    logic [COUNT_WIDTH-1:0] s1_bytes_reg;
    logic [COUNT_WIDTH-1:0] s1_commit_reg;
    logic [COUNT_WIDTH-1:0] s1_body_reg;
    logic                   s1_advance;

    logic                   out_valid_reg;
    hrf_out_t               out_reg;
    hrf_out_t               out_next;

    logic [COUNT_WIDTH-1:0] rest;
    logic [COUNT_WIDTH:0]   sum;

    assign s1_advance = !out_valid_reg || m_ready;
    assign snap_ready = !s1_valid_reg || s1_advance;

    assign rest = s1_bytes_reg - s1_commit_reg;
    assign sum  = {1'b0, s1_commit_reg} + {1'b0, s1_body_reg};

    always_comb begin
        out_next.complete       = s1_body_phase_reg &&
                                  ((s1_body_reg == '0) || (rest >= s1_body_reg));
        out_next.request_length = FIELD_W'(sum[COUNT_WIDTH] ? MAXV : sum[COUNT_WIDTH-1:0]);
        out_next.content_length = FIELD_W'(s1_body_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (snap_ready) s1_valid_reg <= snap_valid;
            if (s1_advance) out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && snap_valid) begin
            s1_body_phase_reg <= snap_body_phase;
            s1_bytes_reg      <= snap_bytes;
            s1_commit_reg     <= snap_committed;
            s1_body_reg       <= snap_body;
        end
        if (s1_advance && s1_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

[rtl/core/hrf_checker.sv]
`timescale 1ns / 1ps

module hrf_checker
    import hrf_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input hrf_in_t  s_item,
    input logic     m_valid,
    input logic     m_ready,
    input hrf_out_t m_item
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a waiting input item keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input item changed while waiting");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // totals stay within the counter range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.request_length >> COUNT_WIDTH) == '0) &&
                    ((m_item.content_length >> COUNT_WIDTH) == '0))
        else $error("result beyond counter range");

    // request length includes the body size
    a_len_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.request_length >= m_item.content_length)
        else $error("request length below content length");

endmodule

bind http_request_framer_unit hrf_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_hrf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

[verif/http_request_framer_unit_tb.sv]
`timescale 1ns / 1ps

module http_request_framer_unit_tb;
    import hrf_pkg::*;

    localparam int COUNT_WIDTH = 32;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [8*NAME_LEN-1:0] LEN_NAME = "Content-Length";
    localparam int MIN_BYTES    = 1400;
    localparam int MIN_FRAMES   = 40;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 1500;
    localparam int IDLE_LIMIT   = 6000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS  = 10;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hrf_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hrf_out_t m_item;

    http_request_framer_unit #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Byte stream waiting for the driver, and frame results still owed by the block.
    hrf_in_t    byte_feed[$];
    hrf_out_t   frames_due[$];
    logic [7:0] frame_bytes[$];
    int         buffers_built = 0;
    int         in_count      = 0;
    int         fail_cnt      = 0;
    logic       in_hs         = 1'b0;
    logic       out_hs        = 1'b0;

    // Framer state mirror
    hrf_phase_t             ph;
    hrf_vstage_t            vst;
    logic                   prev_cr;
    logic [COUNT_WIDTH-1:0] seen_cnt;
    logic [COUNT_WIDTH-1:0] line_end_off;
    logic [COUNT_WIDTH-1:0] body_len;
    logic [COUNT_WIDTH-1:0] acc;
    logic                   has_colon;
    logic [3:0]             match_pos;
    logic                   match_ok;
    logic                   neg;

    task automatic line_reset();
        has_colon = 1'b0;
        match_pos = '0;
        match_ok  = 1'b1;
        vst       = VS_SKIP;
        neg       = 1'b0;
        acc       = '0;
    endtask

    task automatic frame_reset();
        ph           = PH_REQUEST;
        prev_cr      = 1'b0;
        seen_cnt     = '0;
        line_end_off = '0;
        body_len     = '0;
        line_reset();
    endtask

    task automatic frame_byte(input hrf_in_t it);
        logic [7:0]  b;
        logic        is_dig;
        logic        is_space;
        logic [63:0] prod;
        logic [63:0] total;
        hrf_out_t    res;
        b        = it.data_byte;
        is_dig   = (b >= CH_ZERO) && (b <= CH_NINE);
        is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        if (seen_cnt != CNT_MAX) begin
            seen_cnt = seen_cnt + 1'b1;
        end
        if (ph != PH_BODY) begin
            if (b == CH_LF && prev_cr) begin
                line_end_off = seen_cnt;
                if (ph == PH_REQUEST) begin
                    ph = PH_HEADERS;
                end else if (has_colon) begin
                    if (match_ok && match_pos == NAME_LEN) begin
                        body_len = (neg && acc != 0) ? CNT_MAX : acc;
                    end
                end else begin
                    ph = PH_BODY;
                end
                line_reset();
                prev_cr = 1'b0;
            end else begin
                if (ph == PH_HEADERS) begin
                    if (has_colon) begin
                        case (vst)
                            VS_SKIP: begin
                                if (b == CH_PLUS || b == CH_MINUS) begin
                                    neg = (b == CH_MINUS);
                                    vst = VS_SIGN;
                                end else if (!is_space) begin
                                    vst = is_dig ? VS_DIGITS : VS_DONE;
                                end
                            end
                            VS_SIGN: begin
                                vst = is_dig ? VS_DIGITS : VS_DONE;
                            end
                            VS_DIGITS: begin
                                if (!is_dig) begin
                                    vst = VS_DONE;
                                end
                            end
                            default: ;
                        endcase
                        // A sign or skipped space never lands here with a digit.
                        if (vst == VS_DIGITS && is_dig) begin
                            prod = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
                            acc  = (prod > 64'(CNT_MAX)) ? CNT_MAX : prod[COUNT_WIDTH-1:0];
                        end
                    end else if (b == CH_COLON) begin
                        has_colon = 1'b1;
                    end else if (match_ok && match_pos < NAME_LEN &&
                                 b == LEN_NAME[8*(NAME_LEN-1-int'(match_pos)) +: 8]) begin
                        match_pos = match_pos + 1'b1;
                    end else begin
                        match_ok = 1'b0;
                    end
                end
                prev_cr = (b == CH_CR);
            end
        end
        if (it.end_of_buffer) begin
            total              = 64'(line_end_off) + 64'(body_len);
            res.complete       = (ph == PH_BODY) &&
                                 (body_len == 0 || (seen_cnt - line_end_off) >= body_len);
            res.request_length = (total > 64'(CNT_MAX)) ? CNT_MAX : total[COUNT_WIDTH-1:0];
            res.content_length = body_len;
            frames_due.push_back(res);
            frame_reset();
        end
    endtask

    // Stimulus building
    task automatic put_byte(input logic [7:0] b);
        frame_bytes.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            frame_bytes.push_back(s[i]);
        end
    endtask

    task automatic close_buffer();
        hrf_in_t it;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            it.data_byte     = frame_bytes[i];
            it.end_of_buffer = (i == frame_bytes.size() - 1);
            byte_feed.push_back(it);
        end
        frame_bytes.delete();
        buffers_built++;
    endtask

    function automatic string rand_token(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) begin
            s = $sformatf("%s%c", s, 8'($urandom_range(8'h61, 8'h7A)));
        end
        return s;
    endfunction

    task automatic put_pad();
        case ($urandom_range(0, 3))
            0: ;
            1: put_text(" ");
            2: put_text("  ");
            default: put_text("\t ");
        endcase
    endtask

    task automatic put_odd_value();
        case ($urandom_range(0, 8))
            0: put_text($sformatf("\t-%0d", $urandom_range(0, 9)));
            1: put_text(" -0");
            2: put_text($sformatf(" %0d%0d", $urandom, $urandom_range(0, 99)));
            3: put_text($sformatf("+%0d", $urandom_range(0, 99)));
            4: put_text($sformatf("%0dz%0d", $urandom_range(0, 9), $urandom_range(0, 9)));
            5: put_text(" x12");
            6: begin
                put_byte(8'h0B);
                put_byte(8'h0C);
                put_text($sformatf("%0d", $urandom_range(0, 30)));
            end
            7: put_text("+-3");
            default: put_text($sformatf(" %0d", $urandom));
        endcase
    endtask

    task automatic build_request();
        int n_hdr;
        int kind;
        int cl_val;
        int body_n;
        int cut;
        cl_val = 0;
        put_text($sformatf("%s /%s\r\n", rand_token($urandom_range(1, 3)),
                           rand_token($urandom_range(0, 3))));
        n_hdr = $urandom_range(0, 3);
        repeat (n_hdr) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                cl_val = $urandom_range(0, 12);
                put_text("Content-Length:");
                put_pad();
                put_text($sformatf("%0d\r\n", cl_val));
            end else if (kind < 6) begin
                put_text($sformatf("%s: %s\r\n", rand_token($urandom_range(1, 5)),
                                   rand_token($urandom_range(0, 4))));
            end else if (kind == 6) begin
                case ($urandom_range(0, 3))
                    0: put_text("content-length");
                    1: put_text("Content-Len");
                    2: put_text("Content-Lengthh");
                    default: put_text("Content-Length ");
                endcase
                put_text($sformatf(": %0d\r\n", $urandom_range(0, 9)));
            end else if (kind == 7) begin
                put_text("Content-Length:");
                put_odd_value();
                put_text("\r\n");
            end else if (kind == 8) begin
                put_text($sformatf(":%0d\r\n", $urandom_range(0, 9)));
            end else begin
                put_text($sformatf("X-%s:\r\n", rand_token($urandom_range(1, 3))));
            end
        end
        put_text("\r\n");
        case ($urandom_range(0, 3))
            0: body_n = cl_val;
            1: body_n = (cl_val > 0) ? cl_val - 1 : 0;
            2: body_n = cl_val + $urandom_range(1, 3);
            default: body_n = $urandom_range(0, 14);
        endcase
        repeat (body_n) begin
            put_byte(8'($urandom_range(0, 255)));
        end
        // Cut some buffers short to end inside a line.
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, frame_bytes.size());
            frame_bytes = frame_bytes[0:cut-1];
        end
        close_buffer();
    endtask

    task automatic build_noise();
        int n;
        if ($urandom_range(0, 1) == 1) begin
            put_text("G\r\n");
        end
        n = $urandom_range(1, 20);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: put_byte(CH_CR);
                1: put_byte(CH_LF);
                2: put_byte(CH_COLON);
                default: put_byte(8'($urandom_range(0, 255)));
            endcase
        end
        close_buffer();
    endtask

    // Driver: present the next byte at the falling edge, hold until taken.
    int   tx_gap   = 0;
    logic tx_burst = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_hs) begin
            // hold the item
        end else if (tx_gap != 0) begin
            s_valid <= 1'b0;
            tx_gap  <= tx_gap - 1;
        end else if (byte_feed.size() != 0) begin
            s_item  <= byte_feed.pop_front();
            s_valid <= 1'b1;
            tx_gap  <= tx_burst ? 0 : $urandom_range(0, 10);
        end else begin
            s_valid <= 1'b0;
        end
        if ($urandom_range(0, 63) == 0) begin
            tx_burst <= ~tx_burst;
        end
    end

    // Receiver: random wait per result, plus one long hold-off to back up the input.
    int   rdy_wait  = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic rx_burst  = 1'b0;

    always @(negedge aclk) begin
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && in_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else if (out_hs) begin
            w = rx_burst ? 0 : $urandom_range(0, 10);
            rdy_wait <= (w > 0) ? w - 1 : 0;
            m_ready  <= (w == 0);
        end else if (rdy_wait != 0) begin
            rdy_wait <= rdy_wait - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if ($urandom_range(0, 63) == 0) begin
            rx_burst <= ~rx_burst;
        end
    end

    // Monitor: predict on every accepted byte, check every accepted result.
    always @(posedge aclk) begin
        hrf_out_t want;
        in_hs  <= aresetn && s_valid && s_ready;
        out_hs <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            frame_byte(s_item);
            in_count++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS) begin
                    $display("unexpected result: complete %0b request_length %0d %s %0d",
                             m_item.complete, m_item.request_length, "content_length",
                             m_item.content_length);
                end
            end else begin
                want = frames_due.pop_front();
                if (m_item.complete !== want.complete ||
                    m_item.request_length !== want.request_length ||
                    m_item.content_length !== want.content_length) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS) begin
                        $display({"frame mismatch (exp/act): complete %0b/%0b ",
                                  "request_length %0d/%0d content_length %0d/%0d"},
                                 want.complete, m_item.complete,
                                 want.request_length, m_item.request_length,
                                 want.content_length, m_item.content_length);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        frame_reset();

        // Directed buffers
        put_text("G\r\n\r\n");
        close_buffer();
        put_text("G");
        close_buffer();
        put_text("G\r\n");
        close_buffer();
        put_text("G\r\n\r");
        close_buffer();
        put_text("G\r\nContent-Length: 3\r\n\r\nabc");
        close_buffer();
        put_text("G\r\nContent-Length: 5\r\n\r\nab");
        close_buffer();
        put_text("G\r\nContent-Length: -7\r\n\r\n");
        close_buffer();
        put_text("G\r\nContent-Length:-0\r\n\r\n");
        close_buffer();
        put_text("G\r\nContent-Length: +2\r\n\r\nxy");
        close_buffer();
        put_text("G\r\nContent-Length: 99999999999\r\n\r\n");
        close_buffer();
        put_text("G\r\nContent-Length: 4294967295\r\n\r\nq");
        close_buffer();
        put_text("G\r\nContent-Length:");
        put_byte(CH_TAB);
        put_byte(8'h0B);
        put_byte(8'h0C);
        put_byte(CH_CR);
        put_text(" 4x9\r\n\r\nabcd");
        close_buffer();
        put_text("G\r\nContent-Length: abc\r\n\r\n");
        close_buffer();
        put_text("G\rX\r\nContent-Length: 1\r\n\r\nZ");
        close_buffer();
        put_text("G\r\n: 5\r\n\r\n");
        close_buffer();
        put_text("G\r\nContent-Length: 9\r\nContent-Length: 2\r\n\r\nhi");
        close_buffer();
        put_text("G\r\ncontent-length: 4\r\nContent-Lengt: 4\r\n");
        put_text("Content-Lengthh: 4\r\nContent-Length : 4\r\n\r\n");
        close_buffer();
        put_text("G\r\nContent-Length: 6\r\nHost: a");
        close_buffer();
        put_byte(8'hFF);
        put_byte(8'h00);
        close_buffer();

        // Random buffers: mostly well-formed requests, some noise
        while (byte_feed.size() < MIN_BYTES || buffers_built < MIN_FRAMES) begin
            if ($urandom_range(0, 9) < 8) begin
                build_request();
            end else begin
                build_noise();
            end
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (byte_feed.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (frames_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_cnt == 0 && frames_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/hrf_pkg.sv
rtl/core/hrf_front.sv
rtl/core/hrf_queue.sv
rtl/core/hrf_back.sv
rtl/core/hrf_emit.sv
rtl/core/http_request_framer_unit.sv
rtl/core/hrf_checker.sv
verif/http_request_framer_unit_tb.sv
